[src/bbus_pkg.sv]
// Shared types and constants for the 3x3 box-mean unsharp sharpener.
// No dependencies; every other file of the block but bbus_linebuf imports this package.
package bbus_pkg;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int NUM_CHAN   = 3;
  localparam int WIN_SIZE   = 9;
  localparam int ROW_W      = 12;
  localparam int OCOL_W     = 10;
  localparam int WIDTH_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]   HEIGHT_RST = 12'd480;

  typedef logic [PIX_W-1:0] chan_t;
  typedef logic [RGB_W-1:0] rgb_t;

  // Per-pixel control that travels beside the data path.
  typedef struct packed {
    logic              emit_int;  // interior pixel (row-1, col-1) completes here
    logic              emit_bdr;  // this pixel lies on the frame border
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
  } pix_ctl_t;

endpackage

[src/bbus_linebuf.sv]
// Line store: one row of two stacked pixels (rows r-2 and r-1) per column.
// Single write port, single registered read port; depends on nothing else.
module bbus_linebuf #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/bbus_lane.sv]
// One color-channel lane: 3x3 sum, floor mean by reciprocal, sharpen.
// Two register stages; uses bbus_pkg.
module bbus_lane
  import bbus_pkg::*;
(
  input  logic  clk,
  input  logic  load_sum,
  input  logic  load_res,
  input  chan_t taps [WIN_SIZE],
  output chan_t int_val,
  output chan_t bdr_val
);

  localparam int SUM_W       = 12;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = 2 * SUM_W;
  // ceil(2^15 / 9); exact floor for every sum up to 9 * 255.
  localparam logic [SUM_W-1:0] RECIP_9 = 12'd3641;

  function automatic chan_t sharpen(input chan_t p, input chan_t m);
    chan_t           d;
    logic [PIX_W:0]  s;
    d = (p >= m) ? chan_t'(p - m) : p;
    s = {1'b0, p} + {1'b0, d};
    return s[PIX_W] ? d : s[PIX_W-1:0];
  endfunction

  logic [SUM_W-1:0]  row_sum [3];
  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  sum;
  chan_t             center;
  chan_t             newest;
  logic [PROD_W-1:0] prod;
  chan_t             mean;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = SUM_W'(taps[3*i]) + SUM_W'(taps[3*i+1]) + SUM_W'(taps[3*i+2]);
    end
    sum_next = row_sum[0] + row_sum[1] + row_sum[2];
  end

  always_ff @(posedge clk) begin
    if (load_sum) begin
      sum    <= sum_next;
      center <= taps[4];
      newest <= taps[8];
    end
  end

  assign prod = PROD_W'(sum) * PROD_W'(RECIP_9);
  assign mean = prod[RECIP_SHIFT +: PIX_W];

  // Border pixels take a mean of zero.
  always_ff @(posedge clk) begin
    if (load_res) begin
      int_val <= sharpen(center, mean);
      bdr_val <= sharpen(newest, '0);
    end
  end

endmodule

[src/bbus_merge.sv]
// Merge stage: collects the lane results of one pixel and emits up to two
// results, interior first; uses bbus_pkg.
module bbus_merge
  import bbus_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  pix_ctl_t ctl_in,
  input  chan_t    int_rgb [NUM_CHAN],
  input  chan_t    bdr_rgb [NUM_CHAN],
  output logic     advance,
  output logic     res_valid,
  input  logic     res_ready,
  output chan_t    out_red,
  output chan_t    out_green,
  output chan_t    out_blue,
  output logic [ROW_W-1:0]  out_row,
  output logic [OCOL_W-1:0] out_col,
  output logic     last_of_run
);

  logic     busy;
  logic     phase;  // interior result already transferred
  pix_ctl_t ctl;
  logic     show_int;
  logic     res_xfer;
  logic     done;

  assign show_int  = ctl.emit_int && !phase;
  assign res_valid = busy && (show_int || ctl.emit_bdr);
  assign res_xfer  = res_valid && res_ready;
  assign last_of_run = show_int ? !ctl.emit_bdr : 1'b1;
  assign done      = busy && (!res_valid || (res_ready && last_of_run));
  assign advance   = !busy || done;

  assign out_red   = show_int ? int_rgb[0] : bdr_rgb[0];
  assign out_green = show_int ? int_rgb[1] : bdr_rgb[1];
  assign out_blue  = show_int ? int_rgb[2] : bdr_rgb[2];
  assign out_row   = show_int ? ctl.row - 1'b1 : ctl.row;
  assign out_col   = show_int ? ctl.col - 1'b1 : ctl.col;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (advance) begin
      busy  <= in_valid;
      phase <= 1'b0;
    end else if (res_xfer && show_int) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      ctl <= ctl_in;
    end
  end

endmodule

[src/box_blur_unsharp_sharpen.sv]
// Top level of the 3x3 box-mean unsharp sharpener for raster RGB pixels.
// Depends on bbus_pkg, bbus_linebuf, bbus_lane and bbus_merge.
//
// Usage:
//   Pixels enter on the pix channel (pix_valid/pix_ready, red_in, green_in,
//   blue_in) in raster order. Results leave on the res channel
//   (res_valid/res_ready) with sharpened channels, their row and column,
//   and last_of_run set on the final result caused by one input pixel.
//   The cfg channel writes image_width (index 0) and image_height (index 1);
//   any such write restarts the frame at row 0, column 0. cfg_ready is
//   always high; write only while the block is idle.
// Path: a result is shown once the pixel that causes it has passed the
//   line-store read, window, lane sum, mean and sharpen registers.
//   An interior pixel is finished by its lower-right neighbor, so it leaves
//   one row and one column after its own arrival.
// Throughput: one pixel per clock while results are taken. A pixel that
//   causes two results (an interior and a border pixel) holds the pipeline
//   in the merge stage until both leave; one with no result passes silently.
// Reset: counters clear, image_width = 640, image_height = 480. The line
//   store is not cleared; each entry is written in a frame before it reaches
//   a result.
// Stall: when res_ready is low the pipeline holds; pix_ready drops once
//   all four stages are full.
module box_blur_unsharp_sharpen
  import bbus_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  chan_t                 red_in,
  input  chan_t                 green_in,
  input  chan_t                 blue_in,
  output logic                  res_valid,
  input  logic                  res_ready,
  output chan_t                 out_red,
  output chan_t                 out_green,
  output chan_t                 out_blue,
  output logic [ROW_W-1:0]      out_row,
  output logic [OCOL_W-1:0]     out_col,
  output logic                  last_of_run,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EXT_W = 14;

  // Configuration and frame position.
  logic [WIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col_last;
  logic [ROW_W-1:0]   row_last;
  logic [EXT_W-1:0]   width_ext;

  logic cfg_xfer;
  logic cfg_hit;
  logic pix_xfer;

  // Pipeline stage valids and advance enables.
  logic stage1_valid, stage2_valid, stage3_valid;
  logic en1, en2, en3, en4;

  pix_ctl_t ctl_now;
  pix_ctl_t ctl1, ctl2, ctl3;
  logic [COL_W-1:0] col1;
  rgb_t px1;
  rgb_t up1, lo1;
  rgb_t win [WIN_SIZE];

  chan_t lane_taps [NUM_CHAN][WIN_SIZE];
  chan_t int_rgb [NUM_CHAN];
  chan_t bdr_rgb [NUM_CHAN];

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_xfer &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
  assign pix_xfer  = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate width to [3, MAX_WIDTH] and height to at least 3.
  assign width_ext = EXT_W'(image_width);

  always_comb begin
    priority if (width_ext < EXT_W'(3)) begin
      col_last = COL_W'(2);
    end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(width_ext - EXT_W'(1));
    end
  end

  assign row_last = (image_height < ROW_W'(3)) ? ROW_W'(2) : image_height - 1'b1;

  // Advance the raster position; a register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (pix_xfer) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_comb begin
    ctl_now.emit_int = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    ctl_now.emit_bdr = (row == '0) || (col == '0) || (row == row_last) || (col == col_last);
    ctl_now.row      = row;
    ctl_now.col      = OCOL_W'(col);
  end

  // Bubbles collapse: a stage loads when it is empty or its item moves on.
  assign en3       = !stage3_valid || en4;
  assign en2       = !stage2_valid || en3;
  assign en1       = !stage1_valid || en2;
  assign pix_ready = en1;

  // Stage 1: pixel registered, line-store read in flight.
  bbus_linebuf #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W),
    .DATA_W (2 * RGB_W)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (pix_xfer),
    .rd_addr (col),
    .rd_data ({up1, lo1}),
    .wr_en   (stage1_valid && en2),
    .wr_addr (col1),
    .wr_data ({lo1, px1})
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
      stage3_valid <= 1'b0;
    end else begin
      if (en1) stage1_valid <= pix_xfer;
      if (en2) stage2_valid <= stage1_valid;
      if (en3) stage3_valid <= stage2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      ctl1 <= ctl_now;
      col1 <= col;
      px1  <= {red_in, green_in, blue_in};
    end
  end

  // Stage 2: shift the 3x3 window by one column as the item enters.
  always_ff @(posedge clk) begin
    if (stage1_valid && en2) begin
      for (int i = 0; i < 3; i++) begin
        win[3*i]   <= win[3*i+1];
        win[3*i+1] <= win[3*i+2];
      end
      win[2] <= up1;
      win[5] <= lo1;
      win[8] <= px1;
      ctl2   <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (stage2_valid && en3) begin
      ctl3 <= ctl2;
    end
  end

  // Stages 3 and 4: one lane per color channel.
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        lane_taps[k][i] = win[i][RGB_W-1-PIX_W*k -: PIX_W];
      end
    end
  end

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    bbus_lane u_lane (
      .clk      (clk),
      .load_sum (stage2_valid && en3),
      .load_res (stage3_valid && en4),
      .taps     (lane_taps[k]),
      .int_val  (int_rgb[k]),
      .bdr_val  (bdr_rgb[k])
    );
  end

  bbus_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (stage3_valid),
    .ctl_in      (ctl3),
    .int_rgb     (int_rgb),
    .bdr_rgb     (bdr_rgb),
    .advance     (en4),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

endmodule

[src/bbus_checker.sv]
// Port-level checks for box_blur_unsharp_sharpen and the bind that attaches them.
// Depends on bbus_pkg and the top level's port list.
module bbus_checker
  import bbus_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input chan_t             out_red,
  input chan_t             out_green,
  input chan_t             out_blue,
  input logic [ROW_W-1:0]  out_row,
  input logic [OCOL_W-1:0] out_col,
  input logic              last_of_run
);

  // A stalled result holds its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable({out_red, out_green, out_blue, out_row, out_col, last_of_run}))
    else $error("stalled result changed or dropped");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result shown right after reset");

  // A result that is not last is the interior pixel, never on row or column 0.
  a_first_interior: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last_of_run |-> out_row != '0 && out_col != '0)
    else $error("non-final result outside the interior");

  // The border result follows its interior result in the next cycle.
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !last_of_run |=> res_valid && last_of_run)
    else $error("second result of a pair not shown at once");

endmodule

bind box_blur_unsharp_sharpen bbus_checker u_bbus_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .out_red     (out_red),
  .out_green   (out_green),
  .out_blue    (out_blue),
  .out_row     (out_row),
  .out_col     (out_col),
  .last_of_run (last_of_run)
);

[test/tb_box_blur_unsharp_sharpen.sv]
// Self-checking testbench for box_blur_unsharp_sharpen: streams raster RGB frames of many
// sizes through the block, predicts every sharpened border and interior pixel, checks results.
// Depends on bbus_pkg and the box_blur_unsharp_sharpen RTL; reads no files.
module tb_box_blur_unsharp_sharpen;
  import bbus_pkg::*;

  localparam int LINE_MAX      = 1024;     // line store length handed to the block
  localparam int CYCLE_LIMIT   = 200000;   // far above the slowest correct run
  localparam int SETTLE_CYCLES = 8;        // covers the three-stage pipe plus the merge hold
  localparam int RANDOM_PIXELS = 180;
  localparam int IDLE_PCT      = 18;
  localparam int MAX_REPORTS   = 10;

  // Indexes that name no register: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    chan_t             red;
    chan_t             green;
    chan_t             blue;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } sharp_pixel_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_ready;
  chan_t                 red_in    = '0;
  chan_t                 green_in  = '0;
  chan_t                 blue_in   = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  chan_t                 out_red;
  chan_t                 out_green;
  chan_t                 out_blue;
  logic [ROW_W-1:0]      out_row;
  logic [OCOL_W-1:0]     out_col;
  logic                  last_of_run;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit           idle_on        = 1'b1;  // gaps on the pixel side and stalls on the result side
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  sharp_pixel_t pending_pixels[$];      // sharpened pixels still owed by the block

  // Shadow of the block: registers, line stores, window and raster position.
  logic [WIDTH_W-1:0] width_reg  = WIDTH_RST;
  logic [ROW_W-1:0]   height_reg = HEIGHT_RST;
  rgb_t               upper_line [LINE_MAX];
  rgb_t               lower_line [LINE_MAX];
  rgb_t               window     [WIN_SIZE];
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  box_blur_unsharp_sharpen #(.MAX_WIDTH(LINE_MAX)) dut (.*);

  // Clock: period of 2 time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side at random; hold it open while idling is off.
  always @(posedge clk) begin
    res_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Width in use: register clamped to [3, line length].
  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  // Height in use: register clamped to at least 3.
  function automatic int unsigned active_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  // Channel k of a packed pixel: 0 red, 1 green, 2 blue.
  function automatic chan_t channel_of(rgb_t px, int k);
    return px[RGB_W-1-PIX_W*k -: PIX_W];
  endfunction

  // Detail is the excess over the mean, or the pixel itself below the mean;
  // add the detail back unless that overflows, in which case keep the detail alone.
  function automatic chan_t unsharp(int unsigned p, int unsigned mean);
    int unsigned detail;
    int unsigned boosted;
    detail  = (p >= mean) ? p - mean : p;
    boosted = p + detail;
    return (boosted <= 255) ? chan_t'(boosted) : chan_t'(detail);
  endfunction

  // A write to either register restarts the frame; spare indexes are ignored.
  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = data[WIDTH_W-1:0];
      REG_IMAGE_HEIGHT: height_reg = data;
      default:          return;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advance the shadow by one pixel and queue the results it completes.
  function automatic void predict_pixel(chan_t r, chan_t g, chan_t b);
    int unsigned  w;
    int unsigned  h;
    int unsigned  rr;
    int unsigned  cc;
    int unsigned  sum;
    int           n;
    rgb_t         px;
    chan_t        chans [NUM_CHAN];
    sharp_pixel_t found [2];
    w  = active_width();
    h  = active_height();
    rr = row_pos;
    cc = col_pos;
    n  = 0;
    if (cc >= w) cc = 0;
    if (rr >= h) rr = 0;
    px = {r, g, b};

    // Slide the window one column left, then load the new right column.
    for (int i = 0; i < 3; i++) begin
      window[3*i]   = window[3*i+1];
      window[3*i+1] = window[3*i+2];
    end
    window[2] = upper_line[cc];
    window[5] = lower_line[cc];
    window[8] = px;
    upper_line[cc] = lower_line[cc];
    lower_line[cc] = px;

    // The interior pixel up and to the left now has its whole neighborhood.
    if (rr >= 2 && cc >= 2) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        sum = 0;
        for (int i = 0; i < WIN_SIZE; i++) sum += channel_of(window[i], k);
        chans[k] = unsharp(channel_of(window[4], k), sum / WIN_SIZE);
      end
      found[n].red   = chans[0];
      found[n].green = chans[1];
      found[n].blue  = chans[2];
      found[n].row   = ROW_W'(rr - 1);
      found[n].col   = OCOL_W'(cc - 1);
      found[n].last  = 1'b0;
      n++;
    end

    // Border pixels sharpen against a zero mean and leave on arrival.
    if (rr == 0 || cc == 0 || rr == h - 1 || cc == w - 1) begin
      for (int k = 0; k < NUM_CHAN; k++) chans[k] = unsharp(channel_of(px, k), 0);
      found[n].red   = chans[0];
      found[n].green = chans[1];
      found[n].blue  = chans[2];
      found[n].row   = ROW_W'(rr);
      found[n].col   = OCOL_W'(cc);
      found[n].last  = 1'b0;
      n++;
    end

    if (n > 0) found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_pixels.push_back(found[i]);

    cc++;
    if (cc >= w) begin
      cc = 0;
      rr++;
      if (rr >= h) rr = 0;
    end
    col_pos = cc;
    row_pos = rr;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endfunction

  // Compare each result transfer with the oldest pending pixel.
  always @(posedge clk) begin : check_results
    sharp_pixel_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result with nothing pending: row %0d col %0d", out_row, out_col);
      end else begin
        want = pending_pixels.pop_front();
        if (out_red     !== want.red)   note_mismatch("out_red",     want.red,   out_red);
        if (out_green   !== want.green) note_mismatch("out_green",   want.green, out_green);
        if (out_blue    !== want.blue)  note_mismatch("out_blue",    want.blue,  out_blue);
        if (out_row     !== want.row)   note_mismatch("out_row",     want.row,   out_row);
        if (out_col     !== want.col)   note_mismatch("out_col",     want.col,   out_col);
        if (last_of_run !== want.last)  note_mismatch("last_of_run", want.last,  last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Biased channel value: extremes and bands near them show up often.
  function automatic chan_t rand_chan();
    case ($urandom_range(0, 5))
      0:       return chan_t'($urandom_range(200, 255));
      1:       return chan_t'($urandom_range(0, 40));
      2:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return chan_t'($urandom);
    endcase
  endfunction

  // Transfer one pixel; leave valid high so the next pixel can follow at once.
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    red_in    <= r;
    green_in  <= g;
    blue_in   <= b;
    do @(posedge clk); while (!pix_ready);
    predict_pixel(r, g, b);
  endtask

  task automatic send_random_pixel();
    send_pixel(rand_chan(), rand_chan(), rand_chan());
  endtask

  // Drop valid, drain every pending result, then let silent pixels flush out.
  // Count only open cycles on the result side, since a stall holds the pipe.
  task automatic wait_idle();
    int unsigned settled;
    settled   = 0;
    pix_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    while (settled < SETTLE_CYCLES) begin
      @(posedge clk);
      if (res_ready) settled++;
    end
  endtask

  // Transfer one register write; cfg_valid stays high for a following write,
  // so the caller drops it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
  endtask

  // Set both registers while idle, then stream random pixels.
  task automatic run_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input int unsigned count);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
    repeat (count) send_random_pixel();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset sizes: the first pixels of a 640-wide frame are all top-row borders.
  task automatic test_defaults();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    for (int i = 2; i < 12; i++)
      send_pixel(chan_t'(1 << (i % 8)), ~chan_t'(1 << (i % 8)), chan_t'(i * 23));
  endtask

  // Smallest frame: one interior pixel hitting the detail-only and below-mean
  // branches, borders on every side, then the wrap into the next frame.
  task automatic test_corner_frame();
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    cfg_valid <= 1'b0;
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd128, 8'd127);
    send_pixel(8'd200, 8'd10,  8'd100);
    send_pixel(8'd127, 8'd255, 8'd128);
    send_pixel(8'd0,   8'd255, 8'd100);
    send_pixel(8'd0,   8'd255, 8'd100);
    send_pixel(8'd0,   8'd255, 8'd100);
    send_pixel(8'd1,   8'd2,   8'd3);
    send_pixel(8'd128, 8'd127, 8'd254);
    send_pixel(8'd64,  8'd192, 8'd255);
  endtask

  // Register values below and above the usable range clamp; the width field
  // keeps only its low 11 bits.
  task automatic test_size_limits();
    run_frame(12'd0, 12'd0, 12);
    run_frame(12'd1, 12'd1, 10);
    run_frame(12'd2, 12'd2, 10);
    run_frame(12'hFFF, 12'd3, LINE_MAX + 2);
    run_frame(12'd3, 12'hFFF, 15);
  endtask

  // Rewriting the same sizes mid-frame must restart at row 0, column 0.
  task automatic test_restart();
    run_frame(12'd5, 12'd4, 7);
    run_frame(12'd5, 12'd4, 25);
  endtask

  // Writes to spare indexes must neither change sizes nor restart the frame.
  task automatic test_spare_index();
    run_frame(12'd4, 12'd3, 5);
    wait_idle();
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    repeat (10) send_random_pixel();
  endtask

  // Random sizes, mostly small, with whole frames, wraps and partial frames.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        8, 9: begin
          w = $urandom_range(11, 40);
          h = $urandom_range(3, 5);
        end
        7: begin
          w = $urandom_range(41, 100);
          h = 3;
        end
        default: begin
          w = $urandom_range(0, 10);
          h = $urandom_range(0, 8);
        end
      endcase
      wait_idle();
      case ($urandom_range(0, 3))
        0:       write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        1:       write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        default: begin
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
          write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        end
      endcase
      cfg_valid <= 1'b0;
      n = active_width() * active_height();
      n = n + $urandom_range(0, n);
      if (n > 360) n = 360;
      if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
      repeat (n) begin
        // hold a long gap-free, stall-free stretch in the middle of the run
        idle_on = !(sent >= 40 && sent < 150);
        send_random_pixel();
        sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int i = 0; i < WIN_SIZE; i++) window[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_corner_frame();
    test_size_limits();
    test_restart();
    test_spare_index();
    test_random_frames();

    // drain and flush before the verdict
    wait_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
